>>> hw/rtl/swsnd_pkg.sv
// ============================================================================
// swsnd_pkg - shared definitions for the sliding window sender
// Phase and sequencer encodings, packet and event codes, register indexes.
// ============================================================================
package swsnd_pkg;

    localparam int MAX_WINDOW_DEF = 32;

    // transfer phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_END,
        PH_DONE
    } phase_t;

    // sequencer around the shared subtract/compare unit
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_ACK_CLAMP,
        SQ_ACK_SLIDE,
        SQ_CHECK,
        SQ_DIST,
        SQ_ROOM,
        SQ_EMIT
    } seq_state_t;

    // send command types
    localparam logic [1:0] PKT_START = 2'd0;
    localparam logic [1:0] PKT_END   = 2'd1;
    localparam logic [1:0] PKT_DATA  = 2'd2;
    localparam logic [1:0] PKT_DONE  = 2'd3;

    // event kinds
    localparam logic [1:0] KIND_GO      = 2'd0;
    localparam logic [1:0] KIND_RX      = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // received packet type word for ACK
    localparam logic [31:0] RX_ACK = 32'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW    = 2'd0;
    localparam logic [1:0] CFG_CHUNKS    = 2'd1;
    localparam logic [1:0] CFG_START_SEQ = 2'd2;

endpackage

>>> hw/rtl/sliding_window_sender.sv
// ============================================================================
// sliding_window_sender - go-back-N sender control
// Takes go / rx packet / timeout events and issues START, DATA, END and
// transfer-complete send commands, one per cycle while the sink is ready, with tlast on the final one.
// ============================================================================
// Timing: START/END/complete replies come out in the cycle after the request; in
// the data phase a request passes SQ_CHECK (then END) or SQ_CHECK, SQ_DIST and
// SQ_ROOM, an ACK first passing SQ_ACK_CLAMP and SQ_ACK_SLIDE, through the shared
// subtract/compare unit, then one DATA per cycle while the sink is ready, n total,
// n <= MAX_WINDOW. A new request is taken only once the sequencer is back in idle.
// Reset: rst_n async low; phase idle, base/next zero, window 1, chunks 0.
module sliding_window_sender #(
    parameter int MAX_WINDOW = swsnd_pkg::MAX_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // event requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // rx_type[31:0], rx_seq[63:32], rx_short[64], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // send commands
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // seq_num[31:0]
    output logic [2:0]  m_tuser,   // pkt_type[1:0], is_retransmit[2]
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // count width: holds 0..MAX_WINDOW
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int TW = CW + 1;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_WINDOW);
    localparam logic [6:0]    MAX_W7 = 7'(MAX_WINDOW);

    // control state
    swsnd_pkg::seq_state_t state_reg, state_next;
    swsnd_pkg::phase_t     phase_reg, phase_next;
    logic [5:0]  win_size_reg, win_size_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [31:0] start_seq_reg, start_seq_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] next_reg, next_next;
    logic        out_valid_reg, out_valid_next;

    // working and payload registers
    logic [31:0] rx_seq_reg, rx_seq_next;
    logic [31:0] acc_reg, acc_next;
    logic        resend_reg, resend_next;
    logic [CW-1:0] dist_reg, dist_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] k_reg, k_next;
    logic [31:0] seq_reg, seq_next;
    logic [1:0]  out_type_reg, out_type_next;
    logic [31:0] out_seq_reg, out_seq_next;
    logic        out_rt_reg, out_rt_next;
    logic        out_last_reg, out_last_next;

    // shared subtract/compare unit
    logic [31:0] op_a, op_b;
    logic [32:0] diff;
    logic        a_lt_b;

    assign diff   = {1'b0, op_a} - {1'b0, op_b};
    assign a_lt_b = diff[32];

    // request decode
    logic [1:0]  kind;
    logic [31:0] rx_type, rx_seq;
    logic        rx_short, is_ack, seq_match, rx_event;

    assign kind      = s_tuser;
    assign rx_type   = s_tdata[31:0];
    assign rx_seq    = s_tdata[63:32];
    assign rx_short  = s_tdata[64];
    assign is_ack    = (kind == swsnd_pkg::KIND_RX) && !rx_short && (rx_type == swsnd_pkg::RX_ACK);
    assign seq_match = is_ack && (rx_seq == start_seq_reg);
    assign rx_event  = (kind == swsnd_pkg::KIND_RX) || (kind == swsnd_pkg::KIND_TIMEOUT);

    // effective window, saturated to 1..MAX_WINDOW
    logic [6:0]    ws_ext, w_eff_wide;
    logic [CW-1:0] w_eff;

    assign ws_ext     = {1'b0, win_size_reg};
    assign w_eff_wide = (ws_ext == 7'd0) ? 7'd1 : ((ws_ext > MAX_W7) ? MAX_W7 : ws_ext);
    assign w_eff      = w_eff_wide[CW-1:0];

    // room math for the setup step (narrow)
    logic [CW-1:0] room, wrem, fill_cnt, resend_cnt, total_calc;
    logic [TW-1:0] sum_cnt;

    always_comb
    begin
        // chunks left after next, capped at MAX_WINDOW
        if (a_lt_b)
            room = '0;
        else if (diff[31:0] >= 32'(MAX_WINDOW))
            room = MAX_C;
        else
            room = diff[CW-1:0];
        // free window slots; a shrunk window leaves none
        wrem       = (w_eff > dist_reg) ? (w_eff - dist_reg) : '0;
        fill_cnt   = (wrem < room) ? wrem : room;
        resend_cnt = resend_reg ? dist_reg : '0;
        sum_cnt    = TW'(resend_cnt) + TW'(fill_cnt);
        total_calc = (sum_cnt > TW'(MAX_WINDOW)) ? MAX_C : sum_cnt[CW-1:0];
    end

    logic slot_free;
    logic emit_rt, emit_last;

    assign slot_free = !out_valid_reg || m_tready;
    assign emit_rt   = k_reg < rcnt_reg;
    assign emit_last = (TW'(k_reg) + TW'(1)) == TW'(total_reg);

    // outputs and operand select
    always_comb
    begin
        s_tready  = (state_reg == swsnd_pkg::SQ_IDLE) && slot_free;
        cfg_ready = 1'b1;
        m_tvalid  = out_valid_reg;
        m_tdata   = out_seq_reg;
        m_tuser   = {out_rt_reg, out_type_reg};
        m_tlast   = out_last_reg;
        case (state_reg)
            swsnd_pkg::SQ_ACK_CLAMP:
            begin
                op_a = rx_seq_reg;
                op_b = next_reg;
            end
            swsnd_pkg::SQ_ACK_SLIDE:
            begin
                op_a = base_reg;
                op_b = acc_reg;
            end
            swsnd_pkg::SQ_CHECK:
            begin
                op_a = base_reg;
                op_b = chunk_reg;
            end
            swsnd_pkg::SQ_DIST:
            begin
                op_a = next_reg;
                op_b = base_reg;
            end
            swsnd_pkg::SQ_ROOM:
            begin
                op_a = chunk_reg;
                op_b = next_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        win_size_next  = win_size_reg;
        chunk_next     = chunk_reg;
        start_seq_next = start_seq_reg;
        base_next      = base_reg;
        next_next      = next_reg;
        rx_seq_next    = rx_seq_reg;
        acc_next       = acc_reg;
        resend_next    = resend_reg;
        dist_next      = dist_reg;
        rcnt_next      = rcnt_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        seq_next       = seq_reg;
        out_type_next  = out_type_reg;
        out_seq_next   = out_seq_reg;
        out_rt_next    = out_rt_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swsnd_pkg::CFG_WINDOW:    win_size_next  = cfg_data[5:0];
                swsnd_pkg::CFG_CHUNKS:    chunk_next     = cfg_data;
                swsnd_pkg::CFG_START_SEQ: start_seq_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            swsnd_pkg::SQ_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (phase_reg)
                        swsnd_pkg::PH_START:
                        begin
                            if (rx_event && seq_match)
                            begin
                                phase_next  = swsnd_pkg::PH_DATA;
                                base_next   = '0;
                                next_next   = '0;
                                resend_next = 1'b0;
                                state_next  = swsnd_pkg::SQ_CHECK;
                            end
                            else if (rx_event)
                            begin
                                out_valid_next = 1'b1;
                                out_type_next  = swsnd_pkg::PKT_START;
                                out_seq_next   = start_seq_reg;
                                out_rt_next    = 1'b1;
                                out_last_next  = 1'b1;
                            end
                        end
                        swsnd_pkg::PH_DATA:
                        begin
                            if (rx_event)
                            begin
                                rx_seq_next = rx_seq;
                                resend_next = 1'b1;
                                state_next  = is_ack ? swsnd_pkg::SQ_ACK_CLAMP
                                                     : swsnd_pkg::SQ_CHECK;
                            end
                        end
                        swsnd_pkg::PH_END:
                        begin
                            if (rx_event)
                            begin
                                out_valid_next = 1'b1;
                                out_last_next  = 1'b1;
                                if (seq_match)
                                begin
                                    phase_next    = swsnd_pkg::PH_DONE;
                                    out_type_next = swsnd_pkg::PKT_DONE;
                                    out_seq_next  = '0;
                                    out_rt_next   = 1'b0;
                                end
                                else
                                begin
                                    out_type_next = swsnd_pkg::PKT_END;
                                    out_seq_next  = start_seq_reg;
                                    out_rt_next   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // idle or done: only go starts a transfer
                            if (kind == swsnd_pkg::KIND_GO)
                            begin
                                phase_next     = swsnd_pkg::PH_START;
                                base_next      = '0;
                                next_next      = '0;
                                out_valid_next = 1'b1;
                                out_type_next  = swsnd_pkg::PKT_START;
                                out_seq_next   = start_seq_reg;
                                out_rt_next    = 1'b0;
                                out_last_next  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            swsnd_pkg::SQ_ACK_CLAMP:
            begin
                // ack clamped to next
                acc_next   = a_lt_b ? rx_seq_reg : next_reg;
                state_next = swsnd_pkg::SQ_ACK_SLIDE;
            end
            swsnd_pkg::SQ_ACK_SLIDE:
            begin
                if (a_lt_b)
                begin
                    base_next   = acc_reg;
                    resend_next = 1'b0;
                end
                state_next = swsnd_pkg::SQ_CHECK;
            end
            swsnd_pkg::SQ_CHECK:
            begin
                if (!a_lt_b)
                begin
                    // base at or past chunk count: drop in-flight, send END
                    if (slot_free)
                    begin
                        phase_next     = swsnd_pkg::PH_END;
                        out_valid_next = 1'b1;
                        out_type_next  = swsnd_pkg::PKT_END;
                        out_seq_next   = start_seq_reg;
                        out_rt_next    = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = swsnd_pkg::SQ_IDLE;
                    end
                end
                else
                begin
                    state_next = swsnd_pkg::SQ_DIST;
                end
            end
            swsnd_pkg::SQ_DIST:
            begin
                // in-flight count, never above MAX_WINDOW
                dist_next  = diff[CW-1:0];
                state_next = swsnd_pkg::SQ_ROOM;
            end
            swsnd_pkg::SQ_ROOM:
            begin
                total_next = total_calc;
                rcnt_next  = resend_cnt;
                k_next     = '0;
                seq_next   = resend_reg ? base_reg : next_reg;
                state_next = (total_calc == '0) ? swsnd_pkg::SQ_IDLE : swsnd_pkg::SQ_EMIT;
            end
            swsnd_pkg::SQ_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_type_next  = swsnd_pkg::PKT_DATA;
                    out_seq_next   = seq_reg;
                    out_rt_next    = emit_rt;
                    out_last_next  = emit_last;
                    if (!emit_rt)
                        next_next = seq_reg + 32'd1;
                    seq_next = seq_reg + 32'd1;
                    k_next   = k_reg + CW'(1);
                    if (emit_last)
                        state_next = swsnd_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                state_next = swsnd_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swsnd_pkg::SQ_IDLE;
            phase_reg     <= swsnd_pkg::PH_IDLE;
            win_size_reg  <= 6'd1;
            chunk_reg     <= '0;
            start_seq_reg <= '0;
            base_reg      <= '0;
            next_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            win_size_reg  <= win_size_next;
            chunk_reg     <= chunk_next;
            start_seq_reg <= start_seq_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_seq_reg   <= rx_seq_next;
        acc_reg      <= acc_next;
        resend_reg   <= resend_next;
        dist_reg     <= dist_next;
        rcnt_reg     <= rcnt_next;
        total_reg    <= total_next;
        k_reg        <= k_next;
        seq_reg      <= seq_next;
        out_type_reg <= out_type_next;
        out_seq_reg  <= out_seq_next;
        out_rt_reg   <= out_rt_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> hw/rtl/swsnd_checker.sv
// ============================================================================
// swsnd_checker - port-level checks for the sliding window sender
// Watches the command stream and request handshake; bound to the top level.
// ============================================================================
module swsnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // stalled command holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("command changed while stalled");

    // START, END and complete are always the only command of their request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != swsnd_pkg::PKT_DATA) |-> m_tlast)
        else $error("non-data command without tlast");

    // complete report carries zero and is never a resend
    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == swsnd_pkg::PKT_DONE) |-> (m_tdata == 32'd0) && !m_tuser[2])
        else $error("bad transfer-complete fields");

    // no new request while a burst is still mid-way
    a_ready_burst: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tlast)
        else $error("request ready during an unfinished burst");

endmodule

bind sliding_window_sender swsnd_checker u_swsnd_checker (.*);
